// ===== hdl/iee_pkg.sv =====
// Shared types, codes and constants of the infix expression evaluator.
package iee_pkg;

  // Default sizing of the evaluator stacks and arithmetic
  localparam int DEF_STACK_DEPTH = 64;
  localparam int DEF_VALUE_BITS  = 32;

  // Width of the result value field
  localparam int RESULT_W = 32;

  // Depth of the token queue between front and back (power of two)
  localparam int Q_DEPTH = 4;

  // ASCII codes that the evaluator recognizes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Input word: one character and the last-character flag
  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_expr;
  } in_word_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_PAREN = 2'd3
  } status_t;

  // Output word: result value and status
  typedef struct packed {
    logic signed [RESULT_W-1:0] value;
    status_t                    status;
  } out_word_t;

  // Operator stack entries
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_MUL  = 2'd1,
    OP_LPAR = 2'd2
  } op_t;

  // Token classes produced by the front end
  typedef enum logic [2:0] {
    TK_NONE  = 3'd0,
    TK_DIGIT = 3'd1,
    TK_ADD   = 3'd2,
    TK_MUL   = 3'd3,
    TK_LPAR  = 3'd4,
    TK_RPAR  = 3'd5
  } tok_kind_t;

  // Classified character as it travels through the queue
  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       last;
  } token_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    S_FETCH,
    S_EXEC,
    S_DRAIN,
    S_POP,
    S_RED,
    S_MUL
  } back_state_t;

  // First error wins: a later error never replaces an earlier one
  function automatic status_t first_err(status_t cur, status_t e);
    return (cur == ST_OK) ? e : cur;
  endfunction

endpackage

// ===== hdl/iee_front.sv =====
// Front end: accepts characters and classifies them into tokens.
module iee_front (
  input  logic             item_valid,
  output logic             item_ready,
  input  iee_pkg::in_word_t item,
  output logic             tok_valid,
  input  logic             tok_ready,
  output iee_pkg::token_t  tok
);
  import iee_pkg::*;

  tok_kind_t kind;
  logic [7:0] ch;
  logic [7:0] ch_off;

  assign ch     = item.char_in;
  assign ch_off = ch - CH_ZERO;

  // Character decoder
  always_comb begin
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      kind = TK_DIGIT;
    end else begin
      unique case (ch)
        CH_PLUS: kind = TK_ADD;
        CH_STAR: kind = TK_MUL;
        CH_LPAR: kind = TK_LPAR;
        CH_RPAR: kind = TK_RPAR;
        default: kind = TK_NONE;
      endcase
    end
  end

  // Ignored characters are dropped unless they close the expression
  assign tok.kind   = kind;
  assign tok.digit  = ch_off[3:0];
  assign tok.last   = item.end_of_expr;
  assign tok_valid  = item_valid && (kind != TK_NONE || item.end_of_expr);
  assign item_ready = tok_ready;

endmodule

// ===== hdl/iee_queue.sv =====
// Token queue between the front end and the stack engine.
module iee_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  iee_pkg::token_t push_tok,
  output logic            pop_valid,
  input  logic            pop_ready,
  output iee_pkg::token_t pop_tok
);
  import iee_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  token_t        slots [Q_DEPTH];
  logic [PW:0]   wptr;
  logic [PW:0]   rptr;
  logic          full;
  logic          empty;

  assign empty      = (wptr == rptr);
  assign full       = (wptr[PW-1:0] == rptr[PW-1:0]) && (wptr[PW] != rptr[PW]);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_tok    = slots[rptr[PW-1:0]];

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push_valid && push_ready) wptr <= wptr + 1'b1;
      if (pop_valid && pop_ready)   rptr <= rptr + 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_valid && push_ready) slots[wptr[PW-1:0]] <= push_tok;
  end

endmodule

// ===== hdl/iee_back.sv =====
// Stack engine: operand and operator stacks, reductions and result word.
module iee_back #(
  parameter int STACK_DEPTH = iee_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_BITS  = iee_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               tok_valid,
  output logic               tok_ready,
  input  iee_pkg::token_t    tok_in,
  output logic               result_valid,
  input  logic               result_ready,
  output iee_pkg::out_word_t result
);
  import iee_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int H  = (VALUE_BITS + 1) / 2;
  localparam int PW = 2 * H;
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] TWO  = CW'(2);

  // Stack memories; the top of each stack lives in a register
  logic [VALUE_BITS-1:0] opd_mem [STACK_DEPTH];
  op_t                   opr_mem [STACK_DEPTH];

  back_state_t state, state_next;
  back_state_t ret_st, ret_st_next;
  token_t      tok, tok_next;
  logic [CW-1:0] opd_cnt, opd_cnt_next;
  logic [CW-1:0] opr_cnt, opr_cnt_next;
  logic [VALUE_BITS-1:0] opd_top, opd_top_next;
  op_t         opr_top, opr_top_next;
  status_t     err, err_next;
  op_t         red_op, red_op_next;
  logic [VALUE_BITS-1:0] mul_a, mul_a_next;
  logic [VALUE_BITS-1:0] acc, acc_next;
  logic [1:0]  mul_step, mul_step_next;
  logic [VALUE_BITS-1:0] opd_rd_data;
  op_t         opr_rd_data;
  logic        res_valid, res_valid_next;
  out_word_t   res_word, res_word_next;

  logic [CW-1:0] opd_m1, opd_m2, opr_m1, opr_m2;
  logic          opd_we, opr_we;
  logic [H-1:0]  mul_x, mul_y;
  logic [PW-1:0] prod, prod_sh;
  op_t           prec;
  status_t       fin_err;

  assign opd_m1 = opd_cnt - ONE;
  assign opd_m2 = opd_cnt - TWO;
  assign opr_m1 = opr_cnt - ONE;
  assign opr_m2 = opr_cnt - TWO;

  assign result_valid = res_valid;
  assign result       = res_word;

  // Shared multiplier: one half-width partial product per cycle
  always_comb begin
    case (mul_step)
      2'd1:    begin mul_x = H'(mul_a >> H); mul_y = opd_top[H-1:0]; end
      2'd2:    begin mul_x = mul_a[H-1:0];   mul_y = H'(opd_top >> H); end
      default: begin mul_x = mul_a[H-1:0];   mul_y = opd_top[H-1:0]; end
    endcase
  end
  assign prod    = PW'(mul_x) * PW'(mul_y);
  assign prod_sh = prod << H;

  assign prec    = (tok.kind == TK_MUL) ? OP_MUL : OP_ADD;
  assign fin_err = (opd_cnt == '0) ? first_err(err, ST_UNDER) : err;

  // Sequencer: next state and datapath control
  always_comb begin
    state_next     = state;
    ret_st_next    = ret_st;
    tok_next       = tok;
    opd_cnt_next   = opd_cnt;
    opr_cnt_next   = opr_cnt;
    opd_top_next   = opd_top;
    opr_top_next   = opr_top;
    err_next       = err;
    red_op_next    = red_op;
    mul_a_next     = mul_a;
    acc_next       = acc;
    mul_step_next  = mul_step;
    res_valid_next = res_valid && !result_ready;
    res_word_next  = res_word;
    opd_we         = 1'b0;
    opr_we         = 1'b0;
    tok_ready      = 1'b0;

    unique case (state)
      S_FETCH: begin
        tok_ready = 1'b1;
        if (tok_valid) begin
          tok_next   = tok_in;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        // by default the token finishes this cycle
        state_next = tok.last ? S_DRAIN : S_FETCH;
        unique case (tok.kind) inside
          TK_DIGIT: begin
            if (opd_cnt >= FULL) begin
              err_next = first_err(err, ST_OVER);
            end else begin
              opd_we       = (opd_cnt != '0);
              opd_top_next = VALUE_BITS'(tok.digit);
              opd_cnt_next = opd_cnt + ONE;
            end
          end
          TK_ADD, TK_MUL, TK_LPAR: begin
            if (tok.kind != TK_LPAR && opr_cnt != '0 && opr_top != OP_LPAR &&
                opr_top >= prec) begin
              red_op_next  = opr_top;
              opr_cnt_next = opr_m1;
              ret_st_next  = S_EXEC;
              state_next   = S_RED;
            end else if (opr_cnt >= FULL) begin
              err_next = first_err(err, ST_OVER);
            end else begin
              opr_we       = (opr_cnt != '0);
              opr_top_next = (tok.kind == TK_LPAR) ? OP_LPAR : prec;
              opr_cnt_next = opr_cnt + ONE;
            end
          end
          TK_RPAR: begin
            if (opr_cnt != '0 && opr_top != OP_LPAR) begin
              red_op_next  = opr_top;
              opr_cnt_next = opr_m1;
              ret_st_next  = S_EXEC;
              state_next   = S_RED;
            end else if (opr_cnt != '0) begin
              // drop the matching open paren, reload the new top
              opr_cnt_next = opr_m1;
              ret_st_next  = tok.last ? S_DRAIN : S_FETCH;
              state_next   = S_POP;
            end else begin
              err_next = first_err(err, ST_PAREN);
            end
          end
          default: ;
        endcase
      end

      S_DRAIN: begin
        if (opr_cnt != '0) begin
          if (opr_top == OP_LPAR) begin
            opr_cnt_next = opr_m1;
            err_next     = first_err(err, ST_PAREN);
            ret_st_next  = S_DRAIN;
            state_next   = S_POP;
          end else begin
            red_op_next  = opr_top;
            opr_cnt_next = opr_m1;
            ret_st_next  = S_DRAIN;
            state_next   = S_RED;
          end
        end else if (!res_valid || result_ready) begin
          // emit the result and clear the expression state
          res_valid_next       = 1'b1;
          res_word_next.status = fin_err;
          res_word_next.value  = (fin_err == ST_OK) ? RESULT_W'(opd_top) : '0;
          opd_cnt_next         = '0;
          opr_cnt_next         = '0;
          err_next             = ST_OK;
          state_next           = S_FETCH;
        end
      end

      S_POP: begin
        opr_top_next = opr_rd_data;
        state_next   = ret_st;
      end

      S_RED: begin
        opr_top_next = opr_rd_data;
        if (opd_cnt < TWO) begin
          err_next   = first_err(err, ST_UNDER);
          state_next = ret_st;
        end else if (red_op == OP_MUL) begin
          mul_a_next    = opd_rd_data;
          mul_step_next = 2'd0;
          state_next    = S_MUL;
        end else begin
          opd_top_next = opd_rd_data + opd_top;
          opd_cnt_next = opd_m1;
          state_next   = ret_st;
        end
      end

      S_MUL: begin
        case (mul_step)
          2'd0: begin
            acc_next      = prod[VALUE_BITS-1:0];
            mul_step_next = 2'd1;
          end
          2'd1: begin
            acc_next      = acc + prod_sh[VALUE_BITS-1:0];
            mul_step_next = 2'd2;
          end
          default: begin
            opd_top_next  = acc + prod_sh[VALUE_BITS-1:0];
            opd_cnt_next  = opd_m1;
            mul_step_next = 2'd0;
            state_next    = ret_st;
          end
        endcase
      end

      default: state_next = S_FETCH;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FETCH;
      ret_st    <= S_FETCH;
      opd_cnt   <= '0;
      opr_cnt   <= '0;
      err       <= ST_OK;
      res_valid <= 1'b0;
      mul_step  <= 2'd0;
    end else begin
      state     <= state_next;
      ret_st    <= ret_st_next;
      opd_cnt   <= opd_cnt_next;
      opr_cnt   <= opr_cnt_next;
      err       <= err_next;
      res_valid <= res_valid_next;
      mul_step  <= mul_step_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tok      <= tok_next;
    opd_top  <= opd_top_next;
    opr_top  <= opr_top_next;
    red_op   <= red_op_next;
    mul_a    <= mul_a_next;
    acc      <= acc_next;
    res_word <= res_word_next;
  end

  // Stack memories: spill the old top on push, read the entry below the top
  always_ff @(posedge clk) begin
    if (opd_we) opd_mem[opd_m1[AW-1:0]] <= opd_top;
    if (opr_we) opr_mem[opr_m1[AW-1:0]] <= opr_top;
    opd_rd_data <= opd_mem[opd_m2[AW-1:0]];
    opr_rd_data <= opr_mem[opr_m2[AW-1:0]];
  end

endmodule

// ===== hdl/infix_expression_evaluator.sv =====
// Infix expression evaluator top level: front end, token queue and stack engine.
//
// Takes an infix expression one ASCII word at a time ('0'..'9', '+', '*', '(' and
// ')'; anything else ignored) and gives one result word after the word flagged as
// the last one. The front end accepts a word whenever the four-entry token queue
// has room, so input keeps flowing while the stack engine works or a result waits.
// The stack engine fetches and then executes each token; a '+' reduction adds in
// S_RED, a '*' reduction reads the operand in S_RED and then forms three half-width
// partial products on one shared multiplier in S_MUL, a '(' closed by ')' is popped
// in S_POP, a '(' still open at the end is popped in S_POP and flagged as a paren
// error, and the drain state writes the result register. Each operator is reduced once.
module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::DEF_STACK_DEPTH,
  parameter int VALUE_BITS  = iee_pkg::DEF_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  iee_pkg::in_word_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output iee_pkg::out_word_t result
);
  import iee_pkg::*;

  logic   f_valid, f_ready;
  token_t f_tok;
  logic   b_valid, b_ready;
  token_t b_tok;

  // Character classification
  iee_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .tok_valid  (f_valid),
    .tok_ready  (f_ready),
    .tok        (f_tok)
  );

  // Decoupling queue
  iee_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  // Stack engine
  iee_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (b_valid),
    .tok_ready    (b_ready),
    .tok_in       (b_tok),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
